### sv/stis_pkg.sv
// shared types and constants for the sorted-table interval search unit
`timescale 1ns / 1ps
package stis_pkg;

  localparam int IdxW   = 8;
  localparam int ValInW = 32;
  localparam int SlotW  = 8;
  localparam int CfgW   = 9;

  localparam logic [CfgW-1:0] CfgReset = 9'd256;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } stis_cmp_t;

endpackage

### sv/stis_if.sv
// item channels of the sorted-table interval search unit
`timescale 1ns / 1ps
interface stis_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [stis_pkg::IdxW-1:0]           entry_index;
  logic signed [stis_pkg::ValInW-1:0]  entry_value;
  logic signed [stis_pkg::ValInW-1:0]  search_key;

  modport source (output valid, operation, entry_index, entry_value, search_key,
                  input ready);
  modport sink (input valid, operation, entry_index, entry_value, search_key,
                output ready);
endinterface

interface stis_out_if;
  logic                       valid;
  logic                       ready;
  logic [stis_pkg::SlotW-1:0] slot;
  logic                       out_of_range;

  modport source (output valid, slot, out_of_range, input ready);
  modport sink (input valid, slot, out_of_range, output ready);
endinterface

### sv/stis_table.sv
// boundary table memory: one write port, one registered read port
`timescale 1ns / 1ps
module stis_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 8
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic signed [VALUE_WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic signed [VALUE_WIDTH-1:0] rd_data_o
);

  logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

### sv/stis_cmp.sv
// shared signed comparator: key against the entry just read
`timescale 1ns / 1ps
module stis_cmp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic signed [VALUE_WIDTH-1:0] entry_i,
  output stis_pkg::stis_cmp_t           res_o
);

  import stis_pkg::*;

  // lt/gt refer to the key relative to the entry
  always_comb begin
    res_o.lt = key_i < entry_i;
    res_o.eq = key_i == entry_i;
    res_o.gt = key_i > entry_i;
  end

endmodule

### sv/sorted_table_interval_search_unit.sv
// top level: sorted boundary table with binary-search interval lookup
`timescale 1ns / 1ps
// Usage:
//   in_i carries items: operation 0 writes entry_value at entry_index
//   (indexes at or above TABLE_DEPTH are dropped), operation 1 is a query
//   with search_key. A write gives no result; a query gives one result on
//   out_o: slot i with entry i < key <= entry i+1, or slot 0 with
//   out_of_range set when the key is below entry 0 or above the last entry
//   in use. A key equal to entry 0 gives slot 0 in range.
//   cfg_we_i/cfg_wdata_i set the number of entries in use (clamped to
//   2..TABLE_DEPTH); write it only while idle.
// Timing:
//   a write does not leave ST_IDLE. A query reads entry 0, then the last entry, then
//   one entry per binary-search step, all through the single read port of
//   the table and one shared comparator, then loads the result. in_i.ready
//   is low while a query runs.
// Reset: the entry count returns to 256; table contents are undefined
//   until written, with no clearing pass.
// Stall: the result sits in an output register; a new item is taken while
//   it waits, and a later query holds in its last step until it drains.
module sorted_table_interval_search_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [stis_pkg::CfgW-1:0]  cfg_wdata_i,
  stis_in_if.sink                    in_i,
  stis_out_if.source                 out_o
);

  import stis_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  state_e                        state_q, state_d;
  logic [CfgW-1:0]               cnt_q;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic [AW-1:0]                 last_q, last_d;
  logic [AW-1:0]                 lo_q, lo_d;
  logic [AW-1:0]                 hi_q, hi_d;
  logic                          lt_first_q, lt_first_d;
  logic                          eq_first_q, eq_first_d;
  logic                          oor_q, oor_d;
  logic                          out_valid_q, out_valid_d;
  logic [SlotW-1:0]              out_slot_q, out_slot_d;
  logic                          out_oor_q, out_oor_d;

  logic                          in_fire;
  logic                          tbl_we;
  logic [AW-1:0]                 rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  stis_cmp_t                     cmp;

  logic [31:0]                   cnt_clamped;
  logic [AW-1:0]                 last_idx;
  logic [AW-1:0]                 step_lo, step_hi;
  logic                          out_free;

  // midpoint of the current interval, rounded down
  function automatic logic [AW-1:0] rd_addr_mid(input logic [AW-1:0] a,
                                                input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AW:1];
  endfunction

  // clamp the entry count to 2..TABLE_DEPTH
  always_comb begin
    cnt_clamped = 32'(cnt_q);
    if (cnt_clamped < 32'd2) begin
      cnt_clamped = 32'd2;
    end else if (cnt_clamped > 32'(TABLE_DEPTH)) begin
      cnt_clamped = 32'(TABLE_DEPTH);
    end
    last_idx = AW'(cnt_clamped - 32'd1);
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign tbl_we     = in_fire && (in_i.operation == OpWrite)
                      && (32'(in_i.entry_index) < 32'(TABLE_DEPTH));
  assign wr_data    = VALUE_WIDTH'(in_i.entry_value);
  assign out_free   = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CfgReset;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  stis_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .wr_addr_i (AW'(in_i.entry_index)),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stis_cmp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .key_i   (key_q),
    .entry_i (rd_data),
    .res_o   (cmp)
  );

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lt_first_d  = lt_first_q;
    eq_first_d  = eq_first_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_oor_d   = out_oor_q;
    rd_addr     = '0;
    step_lo     = lo_q;
    step_hi     = hi_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.operation == OpQuery)) begin
          key_d   = VALUE_WIDTH'(in_i.search_key);
          last_d  = last_idx;
          rd_addr = '0;
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        lt_first_d = cmp.lt;
        eq_first_d = cmp.eq;
        rd_addr    = last_q;
        state_d    = ST_LAST;
      end
      ST_LAST: begin
        step_lo = '0;
        step_hi = last_q;
        lo_d    = '0;
        hi_d    = last_q;
        oor_d   = lt_first_q || cmp.gt;
        if (lt_first_q || cmp.gt || eq_first_q || (last_q <= AW'(1))) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // entry mid below key moves lo up, otherwise hi comes down
        if (cmp.gt) begin
          step_lo = rd_addr_mid(lo_q, hi_q);
        end else begin
          step_hi = rd_addr_mid(lo_q, hi_q);
        end
        lo_d = step_lo;
        hi_d = step_hi;
        if ((step_hi - step_lo) <= AW'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = SlotW'(lo_q);
          out_oor_d   = oor_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (state_q == ST_LAST || state_q == ST_SEARCH) begin
      rd_addr = rd_addr_mid(step_lo, step_hi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      key_q       <= '0;
      last_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      lt_first_q  <= 1'b0;
      eq_first_q  <= 1'b0;
      oor_q       <= 1'b0;
      out_slot_q  <= '0;
      out_oor_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      key_q       <= key_d;
      last_q      <= last_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      lt_first_q  <= lt_first_d;
      eq_first_q  <= eq_first_d;
      oor_q       <= oor_d;
      out_slot_q  <= out_slot_d;
      out_oor_q   <= out_oor_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.slot         = out_slot_q;
  assign out_o.out_of_range = out_oor_q;

endmodule

### bench/sorted_table_interval_search_unit_test.sv
// testbench for the sorted-table interval search unit: table writes, interval queries, checks
`timescale 1ns / 1ps
module sorted_table_interval_search_unit_test;
  import stis_pkg::*;

  localparam int Depth = 256;
  localparam int SettleCycles = 16;
  localparam int MaxReports = 10;
  localparam int RandomItems = 470;
  localparam int MinPhases = 4;
  localparam longint ValMin = -64'sd2147483648;
  localparam longint ValMax = 64'sd2147483647;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             oor;
  } lookup_t;

  typedef enum logic [1:0] {RowWrite, RowQuery, RowCount} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [IdxW-1:0]    index;
    logic [ValInW-1:0]  value;
    logic               typed;
    logic [SlotW-1:0]   slot;
    logic               oor;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  stis_in_if  in_ch ();
  stis_out_if out_ch ();

  sorted_table_interval_search_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  logic signed [ValInW-1:0] shadow_bounds [Depth];
  int shadow_count = int'(CfgReset);
  lookup_t expected_lookups [$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // table preloaded as a ramp: entry k holds (k - 128) * 1024
  row_t directed_rows [25] = '{
    '{RowQuery, 8'd0,   -32'sd131072,  1'b1, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   -32'sd131073,  1'b1, 8'd0,   1'b1},
    '{RowQuery, 8'd0,   32'h8000_0000, 1'b1, 8'd0,   1'b1},
    '{RowQuery, 8'd0,   32'h7fff_ffff, 1'b1, 8'd0,   1'b1},
    '{RowQuery, 8'd0,   32'sd130048,   1'b1, 8'd254, 1'b0},
    '{RowQuery, 8'd0,   32'sd130049,   1'b1, 8'd0,   1'b1},
    '{RowQuery, 8'd0,   32'sd0,        1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   32'sd1,        1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   -32'sd130000,  1'b0, 8'd0,   1'b0},
    '{RowCount, 8'd0,   32'd0,         1'b0, 8'd0,   1'b0},
    '{RowWrite, 8'd0,   32'h8000_0000, 1'b0, 8'd0,   1'b0},
    '{RowWrite, 8'd1,   32'h7fff_ffff, 1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   32'h8000_0000, 1'b1, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   32'h7fff_ffff, 1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   32'sd0,        1'b0, 8'd0,   1'b0},
    '{RowWrite, 8'd1,   32'h8000_0000, 1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   32'h8000_0001, 1'b1, 8'd0,   1'b1},
    '{RowCount, 8'd0,   32'd511,       1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   -32'sd5,       1'b0, 8'd0,   1'b0},
    '{RowWrite, 8'd255, 32'h8000_0000, 1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   32'sd0,        1'b1, 8'd0,   1'b1},
    '{RowQuery, 8'd0,   32'h8000_0000, 1'b1, 8'd0,   1'b0},
    '{RowCount, 8'd0,   32'd3,         1'b0, 8'd0,   1'b0},
    '{RowWrite, 8'd2,   32'h7fff_ffff, 1'b0, 8'd0,   1'b0},
    '{RowQuery, 8'd0,   32'sd12345,    1'b0, 8'd0,   1'b0}
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // binary search over the shadow table, same step rule as the block
  function automatic lookup_t locate_interval(logic signed [ValInW-1:0] key);
    lookup_t res;
    int lo;
    int hi;
    int mid;
    res = '0;
    if (key < shadow_bounds[0] || key > shadow_bounds[shadow_count-1]) begin
      res.oor = 1'b1;
    end else if (key != shadow_bounds[0]) begin
      lo = 0;
      hi = shadow_count - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (shadow_bounds[mid] < key) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      res.slot = SlotW'(lo);
    end
    return res;
  endfunction

  task automatic note_failure(string what);
    failures++;
    if (failures <= MaxReports) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_item(logic op, logic [IdxW-1:0] idx, logic signed [ValInW-1:0] value,
                           logic signed [ValInW-1:0] key, logic typed, lookup_t typed_result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= value;
    in_ch.search_key  <= key;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (op == OpWrite) begin
      shadow_bounds[idx] = value;
    end else if (typed) begin
      expected_lookups.push_back(typed_result);
    end else begin
      expected_lookups.push_back(locate_interval(key));
    end
  endtask

  // only while idle: drain results, let a trailing write settle, then write
  task automatic set_entry_count(logic [CfgW-1:0] count);
    in_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    shadow_count = (count < 2) ? 2 : ((count > Depth) ? Depth : int'(count));
  endtask

  always @(posedge clk_i) begin : drain_results
    lookup_t want;
    if (rst_ni === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_lookups.size() == 0) begin
          note_failure($sformatf("unexpected result slot %0d out_of_range %0b",
                                 out_ch.slot, out_ch.out_of_range));
        end else begin
          want = expected_lookups.pop_front();
          if (out_ch.slot !== want.slot)
            note_failure($sformatf("slot expected %0d got %0d", want.slot, out_ch.slot));
          if (out_ch.out_of_range !== want.oor)
            note_failure($sformatf("out_of_range expected %0b got %0b",
                                   want.oor, out_ch.out_of_range));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int n;
    int cfg_val;
    int ops;
    int made;
    int phase;
    int pick;
    int k;
    longint step;
    longint span;
    longint level;
    longint lo_b;
    longint hi_b;
    logic signed [ValInW-1:0] key;
    lookup_t none;
    none = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OpWrite;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.search_key = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry gets written before the first query
    for (int e = 0; e < Depth; e++)
      send_item(OpWrite, IdxW'(e), ValInW'((e - 128) * 1024), ValInW'($urandom), 1'b0, none);

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        RowWrite: begin
          send_item(OpWrite, directed_rows[r].index, directed_rows[r].value,
                    ValInW'($urandom), 1'b0, none);
        end
        RowQuery: begin
          send_item(OpQuery, IdxW'($urandom), ValInW'($urandom), directed_rows[r].value,
                    directed_rows[r].typed, lookup_t'({directed_rows[r].slot,
                                                       directed_rows[r].oor}));
        end
        default: begin
          set_entry_count(CfgW'(directed_rows[r].value));
        end
      endcase
    end

    made = 0;
    phase = 0;
    // every idling phase runs at least once
    while (made < RandomItems || phase < MinPhases) begin
      if (phase == 2) begin
        n = Depth;
      end else begin
        case ($urandom_range(0, 5))
          0: n = 2;
          1: n = 3;
          2: n = $urandom_range(4, 9);
          3: n = $urandom_range(16, 17);
          4: n = $urandom_range(10, 64);
          default: n = $urandom_range(65, 255);
        endcase
      end
      cfg_val = n;
      // out-of-range counts alias to the clamp limits
      if (n == 2 && $urandom_range(1) == 1) cfg_val = $urandom_range(0, 1);
      if (n == Depth && $urandom_range(1) == 1) cfg_val = $urandom_range(257, 511);
      set_entry_count(CfgW'(cfg_val));
      n = shadow_count;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase

      // sorted fill of the entries in use, spread picked per phase
      pick = $urandom_range(0, 5);
      case (pick)
        0: step = 0;
        1: step = 3;
        2: step = 1000;
        3: step = 64'd1 << 20;
        default: step = 64'd4294967295 / n;
      endcase
      span = step * (n - 1);
      level = ValMin + longint'($urandom) % (64'sd4294967296 - span);
      if (pick == 5) level = ValMin;
      for (k = 0; k < n; k++) begin
        if (pick == 5 && k == n - 1) level = ValMax;
        send_item(OpWrite, IdxW'(k), ValInW'(level), ValInW'($urandom), 1'b0, none);
        level += longint'($urandom_range(0, 32'(step)));
      end

      ops = 40 + n / 4;
      repeat (ops) begin
        k = $urandom_range(0, n - 1);
        pick = $urandom_range(99);
        if (pick < 70) begin
          case ($urandom_range(0, 6))
            0: key = shadow_bounds[k];
            1: key = shadow_bounds[k] + 1;
            2: key = shadow_bounds[k] - 1;
            3: key = ValInW'($urandom);
            4: key = 32'h8000_0000;
            5: key = 32'h7fff_ffff;
            default: begin
              lo_b = shadow_bounds[k];
              hi_b = (k < n - 1) ? longint'(shadow_bounds[k+1]) : ValMax;
              if (hi_b > lo_b) begin
                key = ValInW'(lo_b + 1 + longint'($urandom) % (hi_b - lo_b));
              end else begin
                key = shadow_bounds[k];
              end
            end
          endcase
          send_item(OpQuery, IdxW'($urandom), ValInW'($urandom), key, 1'b0, none);
        end else if (pick < 85) begin
          // rewrite keeping the order with its neighbors
          lo_b = (k > 0) ? longint'(shadow_bounds[k-1]) : ValMin;
          hi_b = (k < n - 1) ? longint'(shadow_bounds[k+1]) : ValMax;
          level = (hi_b < lo_b) ? lo_b : lo_b + longint'($urandom) % (hi_b - lo_b + 1);
          send_item(OpWrite, IdxW'(k), ValInW'(level), ValInW'($urandom), 1'b0, none);
        end else begin
          // anywhere, any value: may leave the table unsorted
          send_item(OpWrite, IdxW'($urandom), ValInW'($urandom), ValInW'($urandom),
                    1'b0, none);
        end
      end
      made += n + ops;
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("sorted_table_interval_search_unit verification clean");
    end else begin
      $display("sorted_table_interval_search_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("sorted_table_interval_search_unit verification failed");
    $finish;
  end

endmodule

### sorted_table_interval_search_unit.f
sv/stis_pkg.sv
sv/stis_if.sv
sv/stis_table.sv
sv/stis_cmp.sv
sv/sorted_table_interval_search_unit.sv
bench/sorted_table_interval_search_unit_test.sv
